// ----- src/burst_framer_word_packer_defines.svh -----
// ----------------------------------------------------------------------------
// Burst framer word packer: assertion macros
// Concurrent assertion helpers used by the top module's checks.
// ----------------------------------------------------------------------------
`ifndef BURST_FRAMER_WORD_PACKER_DEFINES_SVH
`define BURST_FRAMER_WORD_PACKER_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define BFWP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bfwp assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define BFWP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfwp next-cycle assertion failed");

`else

`define BFWP_ASSERT(label, clk, rst_n, prop)
`define BFWP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/bfwp_pkg.sv -----
// ----------------------------------------------------------------------------
// Burst framer word packer package
// Widths, codes and the push descriptor shared by the framer and the packer.
// ----------------------------------------------------------------------------
package bfwp_pkg;

  // Field widths of the framed bit stream.
  localparam int SyncBits    = 16;
  localparam int LenBits     = 8;
  localparam int CsumBits    = 8;
  localparam int WordBits    = 16;
  localparam int ByteBits    = 8;
  localparam int SlotBits    = 9;
  localparam int CmdBits     = 2;
  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = 16;

  // The accumulator never holds a full word after a pop.
  localparam int HeldBits    = $clog2(WordBits);
  localparam int PushCntBits = HeldBits + 1;

  localparam logic [SlotBits-1:0] PayloadReset = 9'd32;

  // Input commands; the unused code acts as busy.
  typedef enum logic [CmdBits-1:0] {
    CMD_BYTE    = 2'd0,
    CMD_BUSY    = 2'd1,
    CMD_DRAINED = 2'd2
  } cmd_e;

  // Burst phases.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_TX    = 2'd1,
    PH_FLUSH = 2'd2,
    PH_END   = 2'd3
  } phase_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SYNC    = 1'b0,
    CFG_PAYLOAD = 1'b1
  } cfg_reg_e;

  // Bits appended to the stream by one step.
  typedef struct packed {
    logic                   clear;
    logic                   taken;
    logic [PushCntBits-1:0] count;
    logic [WordBits-1:0]    bits;
  } push_t;

endpackage

// ----- src/bfwp_if.sv -----
// ----------------------------------------------------------------------------
// Burst framer word packer channel interfaces
// Valid/ready channels for input bytes, output words and register writes.
// ----------------------------------------------------------------------------

// Input channel: one command and byte per transaction.
interface bfwp_in_if
  import bfwp_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CmdBits-1:0]  command;
  logic [ByteBits-1:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// Output channel: one result per transaction.
interface bfwp_out_if
  import bfwp_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                word_valid;
  logic [WordBits-1:0] out_word;
  logic                byte_taken;

  modport source (output valid, output word_valid, output out_word, output byte_taken,
                  input ready);
  modport sink   (input valid, input word_valid, input out_word, input byte_taken,
                  output ready);
endinterface

// Register write channel.
interface bfwp_cfg_if
  import bfwp_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/bfwp_framer.sv -----
// ----------------------------------------------------------------------------
// Burst framer
// Holds the registers and the burst phase, and decides which bits each step
// appends to the stream.
// ----------------------------------------------------------------------------
module bfwp_framer
  import bfwp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  bfwp_cfg_if.sink            cfg_i,
  input  logic                step_i,
  input  logic [CmdBits-1:0]  cmd_i,
  input  logic [ByteBits-1:0] data_i,
  output push_t               push_o
);

  logic [SyncBits-1:0] sync_q;
  logic [SlotBits-1:0] payload_q;
  phase_e              phase_q, phase_d;
  logic [SlotBits-1:0] slot_q, slot_d;
  logic [SlotBits-1:0] real_q, real_d;
  logic [ByteBits-1:0] xor_q, xor_d;
  logic [SlotBits-1:0] slot_inc;
  logic [SlotBits-1:0] len_full;
  push_t               push;

  // Register writes are always accepted.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q    <= '0;
      payload_q <= PayloadReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_SYNC:    sync_q    <= cfg_i.data[SyncBits-1:0];
        CFG_PAYLOAD: payload_q <= cfg_i.data[SlotBits-1:0];
        default:     sync_q    <= sync_q;
      endcase
    end
  end

  assign slot_inc = slot_q + SlotBits'(1);
  assign len_full = real_q - SlotBits'(1);

  // Next phase, counters and the bits to append.
  always_comb begin
    phase_d = phase_q;
    slot_d  = slot_q;
    real_d  = real_q;
    xor_d   = xor_q;
    push    = '0;
    unique case (phase_q)
      PH_IDLE: begin
        slot_d     = '0;
        real_d     = '0;
        xor_d      = '0;
        push.clear = 1'b1;
        push.bits  = WordBits'(sync_q[SyncBits-1:0]);
        push.count = PushCntBits'(SyncBits);
        phase_d    = PH_TX;
      end
      PH_TX: begin
        if (cmd_i == CMD_BYTE) begin
          push.bits  = WordBits'(data_i);
          push.count = PushCntBits'(ByteBits);
          push.taken = 1'b1;
          real_d     = real_q + SlotBits'(1);
          xor_d      = xor_q ^ data_i;
          slot_d     = slot_inc;
          if (slot_inc == payload_q) begin
            phase_d = PH_END;
          end
        end else if (cmd_i == CMD_DRAINED) begin
          phase_d = PH_FLUSH;
        end
      end
      PH_FLUSH: begin
        push.count = PushCntBits'(ByteBits);
        slot_d     = slot_inc;
        if (slot_inc == payload_q) begin
          phase_d = PH_END;
        end
      end
      PH_END: begin
        push.bits  = WordBits'(len_full[LenBits-1:0])
                   | (WordBits'(xor_q[CsumBits-1:0]) << LenBits);
        push.count = PushCntBits'(LenBits + CsumBits);
        phase_d    = PH_IDLE;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Burst state advances once per step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      slot_q  <= '0;
      real_q  <= '0;
      xor_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      slot_q  <= slot_d;
      real_q  <= real_d;
      xor_q   <= xor_d;
    end
  end

  assign push_o = push;

endmodule

// ----- src/bfwp_packer.sv -----
// ----------------------------------------------------------------------------
// Word packer
// Appends pushed bits to the accumulator, pops a 16-bit word when one is
// complete, and holds the result register of the output channel.
// ----------------------------------------------------------------------------
module bfwp_packer
  import bfwp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  push_t      push_i,
  output logic       out_adv_o,
  bfwp_out_if.source out_o
);

  logic [WordBits-1:0]    acc_q, acc_d;
  logic [HeldBits-1:0]    held_q, held_d;
  logic [WordBits-1:0]    acc_base;
  logic [HeldBits-1:0]    held_base;
  logic [2*WordBits-1:0]  combined;
  logic [PushCntBits-1:0] total;
  logic                   word_vld;
  logic [WordBits-1:0]    word;
  logic                   out_vld_q;
  logic                   word_vld_q;
  logic [WordBits-1:0]    word_q;
  logic                   taken_q;

  // Shift the new bits in above the held ones and pop a full word.
  always_comb begin
    acc_base  = push_i.clear ? '0 : acc_q;
    held_base = push_i.clear ? '0 : held_q;
    combined  = {{WordBits{1'b0}}, acc_base}
              | ((2*WordBits)'(push_i.bits) << held_base);
    total     = PushCntBits'(held_base) + push_i.count;
    if (total >= PushCntBits'(WordBits)) begin
      word_vld = 1'b1;
      word     = combined[WordBits-1:0];
      acc_d    = combined[2*WordBits-1:WordBits];
      held_d   = HeldBits'(total - PushCntBits'(WordBits));
    end else begin
      word_vld = 1'b0;
      word     = '0;
      acc_d    = combined[WordBits-1:0];
      held_d   = total[HeldBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      held_q <= '0;
    end else if (step_i) begin
      acc_q  <= acc_d;
      held_q <= held_d;
    end
  end

  // Result register: loads on a step, empties when the transaction completes.
  assign out_adv_o = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step_i) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      word_vld_q <= word_vld;
      word_q     <= word;
      taken_q    <= push_i.taken;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.word_valid = word_vld_q;
  assign out_o.out_word   = word_q;
  assign out_o.byte_taken = taken_q;

endmodule

// ----- src/burst_framer_word_packer.sv -----
// An accepted input waits in the input register; a step then moves its result into the result register.
// Throughput: one input transaction per cycle unless the output stalls; the input register, the burst
// state update and the result register then each take one step per clock.
// Reset: asynchronous, active low; returns to the idle phase with empty
// accumulator, sync pattern zero and 32 payload slots.
// ----------------------------------------------------------------------------
// Burst framer word packer
// Frames bytes into sync, payload, length and checksum bursts and emits the
// stream as 16-bit words, one result per input transaction.
// ----------------------------------------------------------------------------
`include "burst_framer_word_packer_defines.svh"

module burst_framer_word_packer
  import bfwp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bfwp_cfg_if.sink   cfg_i,
  bfwp_in_if.sink    in_i,
  bfwp_out_if.source out_o
);

  logic                s1_vld_q;
  logic [CmdBits-1:0]  s1_cmd_q;
  logic [ByteBits-1:0] s1_data_q;
  logic                out_adv;
  logic                step;
  logic                in_fire;
  push_t               push;

  // Input register; a step moves its item into the result register.
  assign in_i.ready = !s1_vld_q || out_adv;
  assign in_fire    = in_i.valid && in_i.ready;
  assign step       = s1_vld_q && out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_fire) begin
      s1_vld_q <= 1'b1;
    end else if (step) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q  <= in_i.command;
      s1_data_q <= in_i.data_byte;
    end
  end

  bfwp_framer u_framer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .step_i (step),
    .cmd_i  (s1_cmd_q),
    .data_i (s1_data_q),
    .push_o (push)
  );

  bfwp_packer u_packer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .push_i    (push),
    .out_adv_o (out_adv),
    .out_o     (out_o)
  );

  // Checks on the stage handoff and the result contents.
  `BFWP_ASSERT(a_empty_word_zero, clk_i, rst_ni, (out_o.valid && !out_o.word_valid) |-> (out_o.out_word == '0))
  `BFWP_ASSERT(a_taken_only_bytes, clk_i, rst_ni, (step && push.taken) |-> (s1_cmd_q == CMD_BYTE))
  `BFWP_ASSERT_NEXT(a_s1_holds, clk_i, rst_ni, s1_vld_q && !out_adv, s1_vld_q && $stable(s1_cmd_q) && $stable(s1_data_q))
  `BFWP_ASSERT_NEXT(a_step_loads, clk_i, rst_ni, step, out_o.valid)

endmodule

// ----- verif/burst_framer_word_packer_tb.sv -----
// ----------------------------------------------------------------------------
// Burst framer word packer testbench
// Drives framed byte traffic through the input channel, rewrites the sync
// pattern and payload length between traffic phases, and checks every output
// transaction against a cycle-free model of the framer and packer or a result pinned in the directed
// table. The input side idles and the output side stalls at random; that table opens the run.
// ----------------------------------------------------------------------------
module burst_framer_word_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfwp_pkg::*;

  localparam int ClkHalf        = 2;
  localparam int ResetCycles    = 12;
  localparam int RandomItems    = 1470;
  localparam int StallLimit     = 3000;
  localparam int LongHoldCycles = 300;
  localparam int TailCycles     = 8;
  localparam int LongHoldPhase  = 4;

  // The command code that the block treats as busy.
  localparam logic [CmdBits-1:0] CmdUnused = 2'd3;

  typedef struct packed {
    logic                word_valid;
    logic [WordBits-1:0] out_word;
    logic                byte_taken;
  } word_result_t;

  // A result typed into the directed table overrides the model's result.
  typedef struct packed {
    logic         pinned;
    word_result_t res;
  } pin_t;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_REGS = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CmdBits-1:0]  cmd;
    logic [ByteBits-1:0] data;
    logic [SyncBits-1:0] sync;
    logic [SlotBits-1:0] payload;
    logic                pinned;
    word_result_t        res;
  } plan_row_t;

  localparam int PlanLen = 23;

  // Directed opening: extremes of both registers, every command, bytes offered
  // outside the payload phase, an empty burst and leftover bits at burst end.
  localparam plan_row_t DirectedPlan [PlanLen] = '{
    '{ROW_REGS, CMD_BUSY,    8'h00, 16'hFFFF, 9'd1,   1'b0, '{1'b0, 16'h0000, 1'b0}},
    '{ROW_ITEM, CMD_BYTE,    8'h12, 16'h0000, 9'd0,   1'b1, '{1'b1, 16'hFFFF, 1'b0}},
    '{ROW_ITEM, CMD_BYTE,    8'hFF, 16'h0000, 9'd0,   1'b1, '{1'b0, 16'h0000, 1'b1}},
    '{ROW_ITEM, CMD_BYTE,    8'h3C, 16'h0000, 9'd0,   1'b1, '{1'b1, 16'h00FF, 1'b0}},
    '{ROW_ITEM, CMD_BUSY,    8'h00, 16'h0000, 9'd0,   1'b1, '{1'b1, 16'hFFFF, 1'b0}},
    '{ROW_ITEM, CMD_DRAINED, 8'h00, 16'h0000, 9'd0,   1'b1, '{1'b0, 16'h0000, 1'b0}},
    '{ROW_ITEM, CMD_BYTE,    8'h77, 16'h0000, 9'd0,   1'b1, '{1'b0, 16'h0000, 1'b0}},
    '{ROW_ITEM, CMD_BUSY,    8'h00, 16'h0000, 9'd0,   1'b1, '{1'b1, 16'hFF00, 1'b0}},
    '{ROW_ITEM, CmdUnused,   8'h80, 16'h0000, 9'd0,   1'b1, '{1'b1, 16'hFFFF, 1'b0}},
    '{ROW_ITEM, CmdUnused,   8'h01, 16'h0000, 9'd0,   1'b1, '{1'b0, 16'h0000, 1'b0}},
    '{ROW_ITEM, CMD_BUSY,    8'hFE, 16'h0000, 9'd0,   1'b1, '{1'b0, 16'h0000, 1'b0}},
    '{ROW_ITEM, CMD_BYTE,    8'h00, 16'h0000, 9'd0,   1'b1, '{1'b0, 16'h0000, 1'b1}},
    '{ROW_ITEM, CMD_DRAINED, 8'h00, 16'h0000, 9'd0,   1'b1, '{1'b1, 16'h0000, 1'b0}},
    '{ROW_REGS, CMD_BUSY,    8'h00, 16'h0000, 9'd256, 1'b0, '{1'b0, 16'h0000, 1'b0}},
    '{ROW_ITEM, CMD_BYTE,    8'hA5, 16'h0000, 9'd0,   1'b1, '{1'b1, 16'h0000, 1'b0}},
    '{ROW_ITEM, CMD_BYTE,    8'h80, 16'h0000, 9'd0,   1'b0, '{1'b0, 16'h0000, 1'b0}},
    '{ROW_ITEM, CMD_BYTE,    8'h01, 16'h0000, 9'd0,   1'b0, '{1'b0, 16'h0000, 1'b0}},
    '{ROW_ITEM, CMD_BYTE,    8'hFF, 16'h0000, 9'd0,   1'b0, '{1'b0, 16'h0000, 1'b0}},
    '{ROW_ITEM, CMD_BUSY,    8'h00, 16'h0000, 9'd0,   1'b0, '{1'b0, 16'h0000, 1'b0}},
    '{ROW_ITEM, CMD_BYTE,    8'h55, 16'h0000, 9'd0,   1'b0, '{1'b0, 16'h0000, 1'b0}},
    '{ROW_ITEM, CMD_DRAINED, 8'h00, 16'h0000, 9'd0,   1'b0, '{1'b0, 16'h0000, 1'b0}},
    '{ROW_ITEM, CMD_BYTE,    8'h9C, 16'h0000, 9'd0,   1'b0, '{1'b0, 16'h0000, 1'b0}},
    '{ROW_ITEM, CMD_BUSY,    8'h00, 16'h0000, 9'd0,   1'b0, '{1'b0, 16'h0000, 1'b0}}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bfwp_in_if  in_if ();
  bfwp_out_if out_if ();
  bfwp_cfg_if cfg_if ();

  burst_framer_word_packer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Model state and its copy of the registers.
  phase_e              ph          = PH_IDLE;
  logic [SlotBits-1:0] slot_cnt    = '0;
  logic [SlotBits-1:0] real_cnt    = '0;
  logic [CsumBits-1:0] csum        = '0;
  logic [31:0]         acc         = '0;
  logic [5:0]          held        = '0;
  logic [SyncBits-1:0] sync_reg    = '0;
  logic [SlotBits-1:0] payload_reg = PayloadReset;

  word_result_t pending_words [$];
  pin_t         pinned_words  [$];

  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;
  bit          long_hold_req = 1'b0;

  initial begin
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // Appends count bits of value above the bits already held, LSB first.
  function automatic void append_bits(logic [31:0] value, int unsigned count);
    logic [31:0] mask;
    mask = (count >= 32) ? '1 : ((32'd1 << count) - 32'd1);
    if (held < 6'd32) acc |= (value & mask) << held;
    held = 6'(held + count);
  endfunction

  function automatic void advance_slot();
    slot_cnt = slot_cnt + 1'b1;
    if (slot_cnt == payload_reg) ph = PH_END;
  endfunction

  // One framing step: the phase action, then a word pop once 16 bits wait.
  function automatic word_result_t frame_step(logic [CmdBits-1:0] cmd,
                                              logic [ByteBits-1:0] data);
    word_result_t res;
    res = '0;
    case (ph)
      PH_IDLE: begin
        slot_cnt = '0;
        real_cnt = '0;
        csum     = '0;
        acc      = '0;
        held     = '0;
        append_bits(32'(sync_reg), SyncBits);
        ph = PH_TX;
      end
      PH_TX: begin
        if (cmd == CMD_BYTE) begin
          append_bits(32'(data), ByteBits);
          real_cnt       = real_cnt + 1'b1;
          csum           = csum ^ data;
          res.byte_taken = 1'b1;
          advance_slot();
        end else if (cmd == CMD_DRAINED) begin
          ph = PH_FLUSH;
        end
      end
      PH_FLUSH: begin
        append_bits('0, ByteBits);
        advance_slot();
      end
      default: begin
        append_bits(32'(real_cnt - 1'b1), LenBits);
        append_bits(32'(csum), CsumBits);
        ph = PH_IDLE;
      end
    endcase
    if (held >= 6'd16) begin
      res.word_valid = 1'b1;
      res.out_word   = acc[WordBits-1:0];
      acc            = acc >> WordBits;
      held           = held - 6'd16;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("mismatch on %s at %0t: expected %0h, got %0h", what, $time, want, got);
    mismatches++;
  endtask

  // Tracks register writes and accepted inputs, and checks every result.
  always @(posedge clk_i) begin : check_proc
    word_result_t pred;
    word_result_t want;
    word_result_t got;
    pin_t         pin;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == CFG_SYNC) sync_reg = cfg_if.data;
        else if (cfg_if.index == CFG_PAYLOAD) payload_reg = cfg_if.data[SlotBits-1:0];
      end
      if (in_if.valid && in_if.ready) begin
        pred = frame_step(in_if.command, in_if.data_byte);
        pin  = pinned_words.pop_front();
        pending_words.push_back(pin.pinned ? pin.res : pred);
      end
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        got = '{out_if.word_valid, out_if.out_word, out_if.byte_taken};
        if (pending_words.size() == 0) begin
          report_mismatch("result with nothing pending", 0, got.out_word);
        end else begin
          want = pending_words.pop_front();
          if (got.word_valid !== want.word_valid)
            report_mismatch("word_valid", want.word_valid, got.word_valid);
          if (got.out_word !== want.out_word)
            report_mismatch("out_word", want.out_word, got.out_word);
          if (got.byte_taken !== want.byte_taken)
            report_mismatch("byte_taken", want.byte_taken, got.byte_taken);
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: switches between stall modes, with one long hold on request.
  initial begin : receiver
    int       mode;
    int       mode_left;
    int       hold;
    bit [2:0] pattern_cnt;
    mode        = 0;
    mode_left   = 0;
    pattern_cnt = '0;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        for (hold = 0; hold < LongHoldCycles; hold++) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        pattern_cnt++;
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= (pattern_cnt != 3'd0);
        endcase
      end
    end
  end

  // Presents one input transaction and waits until it is accepted.
  task automatic push_item(logic [CmdBits-1:0] cmd, logic [ByteBits-1:0] data, pin_t pin);
    pinned_words.push_back(pin);
    in_if.valid     <= 1'b1;
    in_if.command   <= cmd;
    in_if.data_byte <= data;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Stops the input and waits for every pending result.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
  endtask

  // Writes both registers back to back while the block is idle.
  task automatic write_regs(logic [SyncBits-1:0] sync, logic [SlotBits-1:0] payload);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_SYNC;
    cfg_if.data  <= sync;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.index <= CFG_PAYLOAD;
    cfg_if.data  <= CfgDataBits'(payload);
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [CmdBits-1:0] pick_command(int drain_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < drain_pct) return CMD_DRAINED;
    if (r < drain_pct + 6) return CMD_BUSY;
    if (r < drain_pct + 9) return CmdUnused;
    return CMD_BYTE;
  endfunction

  // Main sequence: reset, directed table, then randomized traffic phases.
  initial begin : stimulus
    plan_row_t           row;
    pin_t                pin;
    int                  phase_idx;
    int                  n;
    int                  burst_left;
    int                  drain_pct;
    int                  random_items;
    bit                  gappy;
    logic [SyncBits-1:0] sync;
    logic [SlotBits-1:0] payload;

    in_if.valid     <= 1'b0;
    in_if.command   <= CMD_BUSY;
    in_if.data_byte <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= CFG_SYNC;
    cfg_if.data     <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < PlanLen; i++) begin
      row = DirectedPlan[i];
      if (row.kind == ROW_REGS) begin
        drain_results();
        write_regs(row.sync, row.payload);
      end else begin
        pin = '{row.pinned, row.res};
        push_item(row.cmd, row.data, pin);
      end
    end

    // The first phases hit the corner lengths: a length the slot counter has
    // already passed, zero slots with no drain command so the real count wraps,
    // and the longest regular burst.
    phase_idx    = 0;
    random_items = 0;
    burst_left   = 0;
    while (random_items < RandomItems) begin
      case (phase_idx)
        0: begin payload = 9'd2;   n = 520; drain_pct = 0; end
        1: begin payload = 9'd0;   n = 540; drain_pct = 0; end
        2: begin payload = 9'd256; n = 290; drain_pct = 0; end
        default: begin
          payload   = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(13, 64))
                                                 : 9'($urandom_range(1, 12));
          n         = $urandom_range(30, 90);
          drain_pct = $urandom_range(1, 8);
        end
      endcase
      case (phase_idx % 5)
        3: sync = '0;
        4: sync = '1;
        default: sync = SyncBits'($urandom);
      endcase
      gappy = (phase_idx % 3 != 1);

      drain_results();
      write_regs(sync, payload);
      if (phase_idx == LongHoldPhase) long_hold_req = 1'b1;

      for (int k = 0; k < n; k++) begin
        if (gappy && burst_left == 0) begin
          in_if.valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
          burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        push_item(pick_command(drain_pct), ByteBits'($urandom), '0);
        random_items++;
      end
      phase_idx++;
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (pending_words.size() != 0)
      report_mismatch("results never delivered", 0, pending_words.size());
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/bfwp_pkg.sv
src/bfwp_if.sv
src/bfwp_framer.sv
src/bfwp_packer.sv
src/burst_framer_word_packer.sv
verif/burst_framer_word_packer_tb.sv
